>>> rtl/core/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W      = $clog2(DATA_W);

   typedef enum logic [3:0] {
      F_PUSH  = 4'd0,
      F_ADD   = 4'd1,
      F_SUB   = 4'd2,
      F_MUL   = 4'd3,
      F_DIV   = 4'd4,
      F_NEG   = 4'd5,
      F_DUP   = 4'd6,
      F_SWAP  = 4'd7,
      F_PEEK  = 4'd8,
      F_CLEAR = 4'd9,
      F_DUMP  = 4'd10
   } rpn_func_type;

   typedef enum logic [2:0] {
      STAT_OK   = 3'd0,
      STAT_BAD  = 3'd1,
      STAT_FEW  = 3'd2,
      STAT_DIV0 = 3'd3,
      STAT_FULL = 3'd4
   } rpn_status_type;

   typedef struct packed {
      logic [3:0]               func;
      logic signed [DATA_W-1:0] operand;
   } rpn_req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] value;
      logic                     value_valid;
      logic                     last;
   } rpn_rsp_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_NEG,
      ALU_MUL,
      ALU_DIV
   } rpn_alu_op_type;

   typedef struct packed {
      logic           start;
      rpn_alu_op_type op;
   } rpn_alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } rpn_alu_stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH_A,
      S_FETCH_B,
      S_LATCH_B,
      S_EXEC,
      S_ALU_WAIT,
      S_SWAP2,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESP
   } rpn_state_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_ABSA,
      A_ABSB,
      A_MUL,
      A_DIV,
      A_FIX,
      A_DONE
   } rpn_alu_state_type;

endpackage

`default_nettype wire

>>> rtl/core/rpn_ram.sv
`default_nettype none

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/rpn_alu.sv
`default_nettype none

module rpn_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  rpn_pkg::rpn_alu_cmd_type      cmd,
   input  logic [rpn_pkg::DATA_W-1:0]    opa,
   input  logic [rpn_pkg::DATA_W-1:0]    opb,
   output rpn_pkg::rpn_alu_stat_type     stat
);

   import rpn_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

   rpn_alu_state_type state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] result_ff, result_in;

   // The one adder that every operation shares.
   logic [DATA_W-1:0] add_x, add_y;
   logic              add_sub;
   logic [DATA_W:0]   sum;
   logic [DATA_W-1:0] trial;

   assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}}
                + {{DATA_W{1'b0}}, add_sub};
   assign trial = {acc_ff[DATA_W-2:0], q_ff[DATA_W-1]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  ALU_MUL: state_in = A_MUL;
                  ALU_DIV: state_in = A_ABSA;
                  default: state_in = A_DONE;
               endcase
            end
         end
         A_ABSA: state_in = A_ABSB;
         A_ABSB: state_in = A_DIV;
         A_MUL:  state_in = (cnt_ff == LAST_STEP) ? A_DONE : A_MUL;
         A_DIV:  state_in = (cnt_ff == LAST_STEP) ? A_FIX : A_DIV;
         A_FIX:  state_in = A_DONE;
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_comb begin
      add_x     = '0;
      add_y     = '0;
      add_sub   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      unique case (state_ff)
         A_IDLE: begin
            cnt_in = '0;
            if (cmd.start) begin
               unique case (cmd.op)
                  ALU_ADD: begin
                     add_x     = opa;
                     add_y     = opb;
                     result_in = sum[DATA_W-1:0];
                  end
                  ALU_SUB: begin
                     add_x     = opa;
                     add_y     = opb;
                     add_sub   = 1'b1;
                     result_in = sum[DATA_W-1:0];
                  end
                  ALU_NEG: begin
                     add_y     = opb;
                     add_sub   = 1'b1;
                     result_in = sum[DATA_W-1:0];
                  end
                  ALU_MUL, ALU_DIV: begin
                     acc_in = '0;
                     q_in   = opa;
                     b_in   = opb;
                     neg_in = opa[DATA_W-1] ^ opb[DATA_W-1];
                  end
                  default: begin
                     result_in = '0;
                  end
               endcase
            end
         end
         A_ABSA: begin
            add_y   = q_ff;
            add_sub = 1'b1;
            q_in    = q_ff[DATA_W-1] ? sum[DATA_W-1:0] : q_ff;
         end
         A_ABSB: begin
            add_y   = b_ff;
            add_sub = 1'b1;
            b_in    = b_ff[DATA_W-1] ? sum[DATA_W-1:0] : b_ff;
         end
         A_MUL: begin
            // Multiplier bits from the top down; only the low word is kept.
            add_x     = {acc_ff[DATA_W-2:0], 1'b0};
            add_y     = q_ff[DATA_W-1] ? b_ff : '0;
            acc_in    = sum[DATA_W-1:0];
            q_in      = {q_ff[DATA_W-2:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            result_in = sum[DATA_W-1:0];
         end
         A_DIV: begin
            // Restoring step on magnitudes; the carry out means no borrow.
            add_x   = trial;
            add_y   = b_ff;
            add_sub = 1'b1;
            acc_in  = sum[DATA_W] ? sum[DATA_W-1:0] : trial;
            q_in    = {q_ff[DATA_W-2:0], sum[DATA_W]};
            cnt_in  = cnt_ff + 1'b1;
         end
         A_FIX: begin
            add_y     = q_ff;
            add_sub   = 1'b1;
            result_in = neg_ff ? sum[DATA_W-1:0] : q_ff;
         end
         A_DONE: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      b_ff      <= b_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign stat.done   = (state_ff == A_DONE);
   assign stat.result = result_ff;

endmodule

`default_nettype wire

>>> rtl/core/rpn_stack_calculator.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  rpn_req_type (func, operand)
// rsp_      out        rsp_valid/rsp_stall  rpn_rsp_type (status, value, value_valid, last)
//
// One request is worked on at a time; req_stall is low only in the idle state.
// Push, clear, bad codes and early errors answer straight from idle; the others
// first read their operands from the RAM, and mul and div step through the shared
// adder one bit per cycle. A dump reads each entry from the RAM and then sends it.
// Reset empties the stack at once; the stack RAM itself is never cleared.
// The response register lets a new request in while a response is stalled.
module rpn_stack_calculator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rpn_pkg::rpn_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rpn_pkg::rpn_rsp_type rsp_data
);

   import rpn_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

   rpn_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [3:0]        func_ff, func_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] sec_ff, sec_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   rpn_rsp_type       res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rpn_rsp_type       rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              full, has1, has2;
   logic [ADDR_W-1:0] top_addr, sec_addr, push_addr;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   rpn_alu_cmd_type   alu_cmd;
   rpn_alu_stat_type  alu_stat;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == FULL_COUNT);
   assign has1      = (count_ff != '0);
   assign has2      = (count_ff > CNT_W'(1));
   assign top_addr  = ADDR_W'(count_ff - CNT_W'(1));
   assign sec_addr  = ADDR_W'(count_ff - CNT_W'(2));
   assign push_addr = ADDR_W'(count_ff);

   rpn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rpn_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (sec_ff),
      .opb   (top_ff),
      .stat  (alu_stat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.func)
                  F_ADD, F_SUB, F_MUL, F_DIV, F_SWAP:
                     state_in = has2 ? S_FETCH_A : S_RESP;
                  F_NEG, F_PEEK:
                     state_in = has1 ? S_FETCH_A : S_RESP;
                  F_DUP:
                     state_in = (has1 && !full) ? S_FETCH_A : S_RESP;
                  F_DUMP:
                     state_in = has1 ? S_DUMP_RD : S_RESP;
                  default:
                     state_in = S_RESP;
               endcase
            end
         end
         S_FETCH_A: state_in = S_FETCH_B;
         S_FETCH_B: state_in = S_LATCH_B;
         S_LATCH_B: state_in = S_EXEC;
         S_EXEC: begin
            unique case (func_ff)
               F_ADD, F_SUB, F_MUL, F_NEG: state_in = S_ALU_WAIT;
               F_DIV:   state_in = (top_ff == '0) ? S_RESP : S_ALU_WAIT;
               F_SWAP:  state_in = S_SWAP2;
               default: state_in = S_RESP;
            endcase
         end
         S_ALU_WAIT: state_in = alu_stat.done ? S_RESP : S_ALU_WAIT;
         S_SWAP2:    state_in = S_RESP;
         S_DUMP_RD:  state_in = S_DUMP_OUT;
         S_DUMP_OUT: begin
            if (out_free) begin
               state_in = (idx_ff == '0) ? S_IDLE : S_DUMP_RD;
            end
         end
         S_RESP:  state_in = out_free ? S_IDLE : S_RESP;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      func_in      = func_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = push_addr;
      ram_wr_data  = top_ff;
      ram_rd_addr  = top_addr;
      alu_cmd      = '{start: 1'b0, op: ALU_ADD};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in            = req_data.func;
               idx_in             = top_addr;
               res_in.status      = STAT_OK;
               res_in.value       = '0;
               res_in.value_valid = 1'b0;
               res_in.last        = 1'b1;
               unique case (req_data.func)
                  F_PUSH: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = req_data.operand;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  F_ADD, F_SUB, F_MUL, F_DIV, F_SWAP: begin
                     if (!has2) res_in.status = STAT_FEW;
                  end
                  F_NEG, F_PEEK: begin
                     if (!has1) res_in.status = STAT_FEW;
                  end
                  F_DUP: begin
                     if (!has1) begin
                        res_in.status = STAT_FEW;
                     end else if (full) begin
                        res_in.status = STAT_FULL;
                     end
                  end
                  F_CLEAR: count_in = '0;
                  F_DUMP:  res_in.status = STAT_OK;
                  default: res_in.status = STAT_BAD;
               endcase
            end
         end
         S_FETCH_A: begin
            ram_rd_addr = top_addr;
         end
         S_FETCH_B: begin
            ram_rd_addr = sec_addr;
            top_in      = ram_rd_data;
         end
         S_LATCH_B: begin
            ram_rd_addr = sec_addr;
            sec_in      = ram_rd_data;
         end
         S_EXEC: begin
            unique case (func_ff)
               F_ADD: alu_cmd = '{start: 1'b1, op: ALU_ADD};
               F_SUB: alu_cmd = '{start: 1'b1, op: ALU_SUB};
               F_MUL: alu_cmd = '{start: 1'b1, op: ALU_MUL};
               F_NEG: alu_cmd = '{start: 1'b1, op: ALU_NEG};
               F_DIV: begin
                  if (top_ff == '0) begin
                     res_in.status = STAT_DIV0;
                  end else begin
                     alu_cmd = '{start: 1'b1, op: ALU_DIV};
                  end
               end
               F_SWAP: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = top_addr;
                  ram_wr_data = sec_ff;
               end
               F_DUP: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = push_addr;
                  ram_wr_data = top_ff;
                  count_in    = count_ff + 1'b1;
               end
               F_PEEK: begin
                  res_in.value       = top_ff;
                  res_in.value_valid = 1'b1;
               end
               default: begin
                  res_in.status = STAT_BAD;
               end
            endcase
         end
         S_ALU_WAIT: begin
            ram_wr_data = alu_stat.result;
            if (alu_stat.done) begin
               ram_wr_en = 1'b1;
               // Negate rewrites the top; the binary operations fold two into one.
               if (func_ff == F_NEG) begin
                  ram_wr_addr = top_addr;
               end else begin
                  ram_wr_addr = sec_addr;
                  count_in    = count_ff - 1'b1;
               end
            end
         end
         S_SWAP2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sec_addr;
            ram_wr_data = top_ff;
         end
         S_DUMP_RD: begin
            ram_rd_addr = idx_ff;
         end
         S_DUMP_OUT: begin
            // Keep the address so the read data holds while the output is stalled.
            ram_rd_addr = idx_ff;
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = STAT_OK;
               rsp_data_in.value       = ram_rd_data;
               rsp_data_in.value_valid = 1'b1;
               rsp_data_in.last        = (idx_ff == '0);
               idx_in                  = idx_ff - 1'b1;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      top_ff      <= top_in;
      sec_ff      <= sec_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("stack count beyond depth");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> (state_ff == S_ALU_WAIT))
      else $error("arithmetic unit finished while nobody waited");

   a_dump_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP_OUT && out_free && idx_ff != '0) |=> (state_ff == S_DUMP_RD))
      else $error("dump walk did not continue");

endmodule

`default_nettype wire

>>> test/rpn_stack_calculator_tb.sv
`timescale 1ns / 1ps

module rpn_stack_calculator_tb;
   import rpn_pkg::*;

   localparam int          FIRST_BAD_FUNC = 11;
   localparam int          LAST_BAD_FUNC  = 15;
   localparam logic [31:0] MOST_NEG       = 32'h8000_0000;
   localparam logic [31:0] MOST_POS       = 32'h7fff_ffff;
   localparam logic [31:0] MINUS_ONE      = 32'hffff_ffff;
   localparam int          RANDOM_ITEMS   = 250;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          DRAIN_CYCLES   = 100;
   localparam int          TIMEOUT_NS     = 8_000_000;
   localparam int          MAX_REPORTS    = 10;

   typedef struct {
      rpn_req_type req;
      bit          typed;
      rpn_rsp_type want;
   } stim_row_type;

   typedef enum {
      FILL_OFF,
      FILL_PUSH,
      FILL_DUP,
      FILL_DUMP
   } fill_phase_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rpn_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rpn_rsp_type rsp_data;

   logic [31:0]  shadow_stack [STACK_DEPTH];
   int           shadow_count   = 0;
   int           deepest_stack  = 0;
   int           full_rejects   = 0;
   rpn_rsp_type  expected_rsp_q [$];
   stim_row_type directed_rows  [$];
   int           requests_taken  = 0;
   int           results_checked = 0;
   int           mismatches      = 0;
   int           burst_left      = 0;
   bit           hold_request    = 1'b0;
   bit           hold_served     = 1'b0;

   rpn_stack_calculator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d responses still outstanding", expected_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Applies one accepted request to the shadow stack and queues its responses.
   function automatic void predict_calc(rpn_req_type rq);
      logic [31:0] top;
      logic [31:0] sec;
      logic [31:0] res;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      rpn_rsp_type o;
      o        = '0;
      o.status = STAT_OK;
      o.last   = 1'b1;
      case (rq.func)
         F_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               shadow_stack[shadow_count] = rq.operand;
               shadow_count++;
            end
         end
         F_ADD, F_SUB, F_MUL, F_DIV, F_SWAP: begin
            if (shadow_count < 2) begin
               o.status = STAT_FEW;
            end else begin
               top = shadow_stack[shadow_count-1];
               sec = shadow_stack[shadow_count-2];
               if (rq.func == F_SWAP) begin
                  shadow_stack[shadow_count-1] = sec;
                  shadow_stack[shadow_count-2] = top;
               end else if (rq.func == F_DIV && top == '0) begin
                  o.status = STAT_DIV0;
               end else begin
                  case (rq.func)
                     F_ADD: res = sec + top;
                     F_SUB: res = sec - top;
                     F_MUL: res = sec * top;
                     default: begin
                        // Divide magnitudes, then restore the sign; this truncates
                        // toward zero and lets the most negative value wrap.
                        mag_a = sec[31] ? -sec : sec;
                        mag_b = top[31] ? -top : top;
                        res   = mag_a / mag_b;
                        if (sec[31] != top[31]) res = -res;
                     end
                  endcase
                  shadow_stack[shadow_count-2] = res;
                  shadow_count--;
               end
            end
         end
         F_NEG: begin
            if (shadow_count < 1) o.status = STAT_FEW;
            else shadow_stack[shadow_count-1] = -shadow_stack[shadow_count-1];
         end
         F_DUP: begin
            if (shadow_count < 1) begin
               o.status = STAT_FEW;
            end else if (shadow_count >= STACK_DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
               shadow_count++;
            end
         end
         F_PEEK: begin
            if (shadow_count < 1) begin
               o.status = STAT_FEW;
            end else begin
               o.value       = shadow_stack[shadow_count-1];
               o.value_valid = 1'b1;
            end
         end
         F_CLEAR: shadow_count = 0;
         F_DUMP: begin
            if (shadow_count > 0) begin
               for (int i = shadow_count - 1; i >= 0; i--) begin
                  o.value       = shadow_stack[i];
                  o.value_valid = 1'b1;
                  o.last        = (i == 0);
                  expected_rsp_q.push_back(o);
               end
               return;
            end
         end
         default: o.status = STAT_BAD;
      endcase
      if (o.status == STAT_FULL) full_rejects++;
      if (shadow_count > deepest_stack) deepest_stack = shadow_count;
      expected_rsp_q.push_back(o);
   endfunction

   function automatic void add_cmd(logic [3:0] f, logic [31:0] v);
      stim_row_type row;
      row.req.func    = f;
      row.req.operand = v;
      row.typed       = 1'b0;
      row.want        = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic [3:0] f, logic [31:0] v, logic [2:0] st,
                                       logic [31:0] val, logic vv);
      stim_row_type row;
      row.req.func         = f;
      row.req.operand      = v;
      row.typed            = 1'b1;
      row.want.status      = st;
      row.want.value       = val;
      row.want.value_valid = vv;
      row.want.last        = 1'b1;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MINUS_ONE;
         2: return MOST_NEG;
         3: return MOST_POS;
         4: return 32'd1;
         5, 6: return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic rpn_req_type pick_request();
      rpn_req_type rq;
      int          pick;
      rq.operand = pick_operand();
      pick       = $urandom_range(0, 99);
      if (pick < 8) begin
         rq.func = 4'($urandom_range(0, 15));
      end else if (shadow_count < 2 && pick < 70) begin
         rq.func = F_PUSH;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      rq.func = F_PUSH;
         else if (pick < 40) rq.func = F_ADD;
         else if (pick < 48) rq.func = F_SUB;
         else if (pick < 56) rq.func = F_MUL;
         else if (pick < 66) rq.func = F_DIV;
         else if (pick < 71) rq.func = F_NEG;
         else if (pick < 77) rq.func = F_DUP;
         else if (pick < 83) rq.func = F_SWAP;
         else if (pick < 90) rq.func = F_PEEK;
         else if (pick < 95) rq.func = F_DUMP;
         else if (pick < 97) rq.func = F_CLEAR;
         else                rq.func = 4'($urandom_range(FIRST_BAD_FUNC, LAST_BAD_FUNC));
      end
      return rq;
   endfunction

   // Offers one request, with random gaps between bursts, and predicts it once taken.
   task automatic offer(rpn_req_type rq, bit typed, rpn_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      requests_taken++;
      predict_calc(rq);
      if (typed) expected_rsp_q[expected_rsp_q.size() - 1] = want;
      burst_left--;
   endtask

   initial begin : stimulus
      rpn_req_type    rq;
      fill_phase_type fill;
      int             fill_at;
      int             hold_at;

      add_checked(F_PEEK,  '0,        STAT_FEW,  '0,       1'b0);
      add_checked(F_ADD,   '0,        STAT_FEW,  '0,       1'b0);
      add_checked(F_DUMP,  '0,        STAT_OK,   '0,       1'b0);
      add_checked(F_PUSH,  MOST_NEG,  STAT_OK,   '0,       1'b0);
      add_checked(F_SWAP,  '0,        STAT_FEW,  '0,       1'b0);
      add_checked(F_NEG,   MOST_POS,  STAT_OK,   '0,       1'b0);
      add_checked(F_PEEK,  '0,        STAT_OK,   MOST_NEG, 1'b1);
      add_checked(F_PUSH,  MINUS_ONE, STAT_OK,   '0,       1'b0);
      add_checked(F_DIV,   '0,        STAT_OK,   '0,       1'b0);
      add_checked(F_PEEK,  '0,        STAT_OK,   MOST_NEG, 1'b1);
      add_checked(F_PUSH,  '0,        STAT_OK,   '0,       1'b0);
      add_checked(F_DIV,   '0,        STAT_DIV0, '0,       1'b0);
      add_cmd(F_PUSH, MOST_POS);
      add_cmd(F_ADD,  '0);
      add_cmd(F_SUB,  '0);
      add_cmd(F_PUSH, -32'sd7);
      add_cmd(F_MUL,  '0);
      add_cmd(F_PUSH, 32'd2);
      add_cmd(F_DIV,  '0);
      add_cmd(F_PUSH, 32'd5);
      add_cmd(F_SWAP, '0);
      add_cmd(F_DUP,  MINUS_ONE);
      add_cmd(F_DUMP, '0);
      add_checked(4'(FIRST_BAD_FUNC), '0, STAT_BAD, '0, 1'b0);
      add_checked(4'(LAST_BAD_FUNC),  MINUS_ONE, STAT_BAD, '0, 1'b0);
      add_checked(F_CLEAR, '0, STAT_OK, '0, 1'b0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i].req, directed_rows[i].typed,
                                       directed_rows[i].want);

      // Random part: mostly legal RPN traffic, with occasional fills to the top
      // of the stack so that full rejections and long dumps happen.
      fill    = FILL_OFF;
      fill_at = $urandom_range(40, 200);
      hold_at = $urandom_range(60, 180);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == hold_at) hold_request = 1'b1;
         if (fill == FILL_OFF && (n == fill_at || $urandom_range(0, 119) == 0)) begin
            fill = FILL_PUSH;
         end
         case (fill)
            FILL_PUSH: begin
               rq.func    = F_PUSH;
               rq.operand = pick_operand();
               if (shadow_count >= STACK_DEPTH) fill = FILL_DUP;
            end
            FILL_DUP: begin
               rq.func    = F_DUP;
               rq.operand = pick_operand();
               fill       = FILL_DUMP;
            end
            FILL_DUMP: begin
               rq.func    = F_DUMP;
               rq.operand = pick_operand();
               fill       = FILL_OFF;
            end
            default: rq = pick_request();
         endcase
         offer(rq, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d responses, all operations and error codes,",
               requests_taken, results_checked);
      $display("stack depth up to %0d with %0d full rejections and one long output hold-off.",
               deepest_stack, full_rejects);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatching responses", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // The receiver changes its stall pattern in segments, and once holds off
   // for a long stretch so that the block backs up into its request side.
   initial begin : receiver
      int seg_len;
      int stall_pct;
      forever begin
         seg_len = $urandom_range(10, 60);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 80;
         endcase
         repeat (seg_len) begin
            @(negedge clock);
            if (hold_request && !hold_served) begin
               rsp_stall  <= 1'b1;
               hold_served = 1'b1;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
            end else begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rpn_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("Unexpected response: status %0d value %0d valid %0b last %0b",
                        rsp_data.status, rsp_data.value, rsp_data.value_valid,
                        rsp_data.last);
            end
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.value !== want.value ||
                rsp_data.value_valid !== want.value_valid || rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("Response %0d: expected status %0d value %0d valid %0b last %0b",
                           results_checked, want.status, want.value, want.value_valid,
                           want.last);
                  $display("             got      status %0d value %0d valid %0b last %0b",
                           rsp_data.status, rsp_data.value, rsp_data.value_valid,
                           rsp_data.last);
               end
            end
         end
      end
   end

endmodule
